[sv/decimal_accumulator_cpu_step_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decimal accumulator step engine
// Expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_ACCUMULATOR_CPU_STEP_TOP_ASSERT_SVH
`define DECIMAL_ACCUMULATOR_CPU_STEP_TOP_ASSERT_SVH

// same-cycle implication
`define DACC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dacc assertion failed: same-cycle implication");

// next-cycle implication
`define DACC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dacc assertion failed: next-cycle implication");

`endif

[sv/dacc_pkg.sv]
// ----------------------------------------------------------------------------
// dacc_pkg
// Shared constants, codes and decode helpers for the decimal accumulator.
// ----------------------------------------------------------------------------
package dacc_pkg;

    localparam int MEM_WORDS  = 100;
    localparam int WORD_BITS  = 16;
    localparam int ADDR_W     = $clog2(MEM_WORDS);

    localparam int PC_W       = 7;
    localparam int LEN_W      = 7;
    localparam int OP_W       = 2;
    localparam int FIELD_W    = 16;
    localparam int FAULT_W    = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [PC_W-1:0]      pc_t;

    // transaction op codes
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE   = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_HALTED = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_RANGE  = 2'd2;

    // register index (paddr[2])
    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        OPC_NOP    = 3'd0,
        OPC_ADD    = 3'd1,
        OPC_SUB    = 3'd2,
        OPC_STORE  = 3'd3,
        OPC_LOAD   = 3'd5,
        OPC_BRANCH = 3'd6,
        OPC_BRZ    = 3'd7
    } opcode_t;

    typedef struct packed {
        opcode_t opcode;
        pc_t     addr;
    } instr_t;

    // Decimal split of an instruction word. Only words below 800 carry a
    // live opcode, so the hundreds digit comes from seven compares.
    function automatic instr_t decode(word_t w);
        logic [9:0] low;
        logic [9:0] base;
        logic [2:0] q;
        instr_t     r;
        low = w[9:0];
        q   = 3'd0;
        for (int k = 1; k < 8; k++) begin
            if (low >= 10'(k * 100))
                q = 3'(k);
        end
        base   = 10'(q) * 10'd100;
        r.addr = 7'(low - base);
        if (w[WORD_BITS-1] || (w >= word_t'(800))) begin
            r.opcode = OPC_NOP;
        end else begin
            case (q)
                OPC_ADD:    r.opcode = OPC_ADD;
                OPC_SUB:    r.opcode = OPC_SUB;
                OPC_STORE:  r.opcode = OPC_STORE;
                OPC_LOAD:   r.opcode = OPC_LOAD;
                OPC_BRANCH: r.opcode = OPC_BRANCH;
                OPC_BRZ:    r.opcode = OPC_BRZ;
                default:    r.opcode = OPC_NOP;
            endcase
        end
        return r;
    endfunction

    function automatic word_t word_from_field(logic signed [FIELD_W-1:0] v);
        return WORD_BITS'(v);
    endfunction

endpackage

[sv/dacc_if.sv]
// ----------------------------------------------------------------------------
// dacc channel interfaces
// Command and response channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dacc_cmd_if;
    import dacc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [PC_W-1:0]           load_address;
    logic signed [FIELD_W-1:0] load_word;

    modport source (output valid, output op, output load_address, output load_word,
                    input ready);
    modport sink   (input valid, input op, input load_address, input load_word,
                    output ready);
endinterface

interface dacc_rsp_if;
    import dacc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [PC_W-1:0]           pc;
    logic signed [FIELD_W-1:0] accumulator;
    logic                      halted;
    logic [FAULT_W-1:0]        fault;

    modport source (output valid, output pc, output accumulator, output halted,
                    output fault, input ready);
    modport sink   (input valid, input pc, input accumulator, input halted,
                    input fault, output ready);
endinterface

[sv/dacc_ram.sv]
// ----------------------------------------------------------------------------
// dacc_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dacc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/decimal_accumulator_cpu_step_top.sv]
// ----------------------------------------------------------------------------
// decimal_accumulator_cpu_step_top
// One transaction at a time; no new command is taken until the last one has
// left S_DONE, since the single program memory port serves the fetch,
// operand and halt-check reads in turn.
// A response may wait in the output register while the next command is taken.
// rst_n (async, active low) clears PC, accumulator and program_length;
// program memory is not cleared and holds nothing until loaded.
// ----------------------------------------------------------------------------
`include "decimal_accumulator_cpu_step_top_assert.svh"

module decimal_accumulator_cpu_step_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dacc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [dacc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dacc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    dacc_cmd_if.sink                          cmd,
    dacc_rsp_if.source                        rsp
);

    import dacc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_OPER,
        S_CHK,
        S_CHKW,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    pc_t                  pc_reg, pc_next;
    word_t                acc_reg, acc_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    opcode_t              opc_reg, opc_next;
    logic                 halted_reg, halted_next;
    logic [FAULT_W-1:0]   fault_reg, fault_next;

    logic                 out_valid_reg, out_valid_next;
    pc_t                  out_pc_reg, out_pc_next;
    logic [FIELD_W-1:0]   out_acc_reg, out_acc_next;
    logic                 out_halted_reg, out_halted_next;
    logic [FAULT_W-1:0]   out_fault_reg, out_fault_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    word_t                ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    word_t                ram_rdata;

    logic [LEN_W-1:0]     used_len;
    logic                 cmd_fire;
    logic                 cfg_we;
    instr_t               dec;

    dacc_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // APB register access
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_PROGRAM_LENGTH);
    assign prdata = (paddr[2] == REG_PROGRAM_LENGTH) ? APB_DATA_W'(len_reg) : '0;

    assign used_len  = (len_reg > LEN_W'(MEM_WORDS)) ? LEN_W'(MEM_WORDS) : len_reg;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign dec       = decode(ram_rdata);

    assign rsp.valid       = out_valid_reg;
    assign rsp.pc          = out_pc_reg;
    assign rsp.accumulator = out_acc_reg;
    assign rsp.halted      = out_halted_reg;
    assign rsp.fault       = out_fault_reg;

    always_comb
    begin
        state_next      = state_reg;
        pc_next         = pc_reg;
        acc_next        = acc_reg;
        len_next        = cfg_we ? pwdata[LEN_W-1:0] : len_reg;
        opc_next        = opc_reg;
        halted_next     = halted_reg;
        fault_next      = fault_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_pc_next     = out_pc_reg;
        out_acc_next    = out_acc_reg;
        out_halted_next = out_halted_reg;
        out_fault_next  = out_fault_reg;

        ram_we    = 1'b0;
        ram_waddr = cmd.load_address[ADDR_W-1:0];
        ram_wdata = word_from_field(cmd.load_word);
        ram_raddr = pc_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    fault_next = FAULT_NONE;
                    case (cmd.op)
                        OP_LOAD:
                        begin
                            if (cmd.load_address < PC_W'(MEM_WORDS))
                                ram_we = 1'b1;
                            state_next = S_CHK;
                        end
                        OP_STEP:
                        begin
                            // fetch read at pc goes out this cycle
                            if (pc_reg >= used_len)
                            begin
                                fault_next  = FAULT_HALTED;
                                halted_next = 1'b1;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_DEC;
                            end
                        end
                        OP_RESTART:
                        begin
                            pc_next    = '0;
                            acc_next   = '0;
                            state_next = S_CHK;
                        end
                        default:
                        begin
                            state_next = S_CHK;
                        end
                    endcase
                end
            end

            S_DEC:
            begin
                opc_next = dec.opcode;
                if (ram_rdata == '0)
                begin
                    fault_next  = FAULT_HALTED;
                    halted_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    case (dec.opcode)
                        OPC_ADD, OPC_SUB, OPC_LOAD:
                        begin
                            if (dec.addr >= used_len)
                            begin
                                fault_next  = FAULT_RANGE;
                                halted_next = 1'b0;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ram_raddr  = dec.addr[ADDR_W-1:0];
                                state_next = S_OPER;
                            end
                        end
                        OPC_STORE:
                        begin
                            if (dec.addr >= used_len)
                            begin
                                fault_next  = FAULT_RANGE;
                                halted_next = 1'b0;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = dec.addr[ADDR_W-1:0];
                                ram_wdata = acc_reg;
                                // zero stored onto the current word halts in place
                                if (!((dec.addr == pc_reg) && (acc_reg == '0)))
                                    pc_next = pc_reg + 7'd1;
                                state_next = S_CHK;
                            end
                        end
                        OPC_BRANCH:
                        begin
                            pc_next    = dec.addr;
                            state_next = S_CHK;
                        end
                        OPC_BRZ:
                        begin
                            pc_next    = (acc_reg == '0) ? dec.addr : pc_reg + 7'd1;
                            state_next = S_CHK;
                        end
                        default:
                        begin
                            pc_next    = pc_reg + 7'd1;
                            state_next = S_CHK;
                        end
                    endcase
                end
            end

            S_OPER:
            begin
                case (opc_reg)
                    OPC_ADD: acc_next = acc_reg + ram_rdata;
                    OPC_SUB: acc_next = acc_reg - ram_rdata;
                    default: acc_next = ram_rdata;
                endcase
                pc_next    = pc_reg + 7'd1;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                // read at pc issued here; its word is used only when pc is inside the program
                if (pc_reg >= used_len)
                begin
                    halted_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_CHKW;
                end
            end

            S_CHKW:
            begin
                halted_next = (ram_rdata == '0);
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_pc_next     = pc_reg;
                    out_acc_next    = FIELD_W'(acc_reg);
                    out_halted_next = halted_reg;
                    out_fault_next  = fault_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pc_reg         <= '0;
            acc_reg        <= '0;
            len_reg        <= '0;
            opc_reg        <= OPC_NOP;
            halted_reg     <= 1'b0;
            fault_reg      <= FAULT_NONE;
            out_valid_reg  <= 1'b0;
            out_pc_reg     <= '0;
            out_acc_reg    <= '0;
            out_halted_reg <= 1'b0;
            out_fault_reg  <= FAULT_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            acc_reg        <= acc_next;
            len_reg        <= len_next;
            opc_reg        <= opc_next;
            halted_reg     <= halted_next;
            fault_reg      <= fault_next;
            out_valid_reg  <= out_valid_next;
            out_pc_reg     <= out_pc_next;
            out_acc_reg    <= out_acc_next;
            out_halted_reg <= out_halted_next;
            out_fault_reg  <= out_fault_next;
        end
    end

    // a step that found the machine halted must still report it halted
    `DACC_ASSERT_IMPL(a_halt_fault, out_valid_reg && (out_fault_reg == FAULT_HALTED), out_halted_reg)
    // an operand range fault leaves a live word at pc
    `DACC_ASSERT_IMPL(a_range_fault, out_valid_reg && (out_fault_reg == FAULT_RANGE), !out_halted_reg)
    // a running machine has its pc inside the program
    `DACC_ASSERT_IMPL(a_pc_in_prog, out_valid_reg && !out_halted_reg, out_pc_reg < used_len)
    // one transaction in flight at a time
    `DACC_ASSERT_NEXT(a_one_at_a_time, cmd_fire, !cmd.ready)

endmodule
